// ===== src/asp_pkg.sv =====
// Shared types, constants and helper functions of the angle sentence parser.
package asp_pkg;

  localparam int unsigned LINE_CAPACITY = 48;
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);

  localparam logic [3:0] PH_PREFIX     = 4'd0;
  localparam logic [3:0] PH_FLAG       = 4'd1;
  localparam logic [3:0] PH_YAW_SIGN   = 4'd2;
  localparam logic [3:0] PH_YAW_INT    = 4'd3;
  localparam logic [3:0] PH_YAW_FRAC   = 4'd4;
  localparam logic [3:0] PH_PITCH_SIGN = 4'd5;
  localparam logic [3:0] PH_PITCH_INT  = 4'd6;
  localparam logic [3:0] PH_PITCH_FRAC = 4'd7;
  localparam logic [3:0] PH_TARGET     = 4'd8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0]  PREFIX_LEN = 3'd6;
  localparam logic [16:0] ACCUM_MAX  = 17'h1FFFF;

  typedef struct packed {
    logic        valid;
    logic        accepted;
    logic        flag_nz;
    logic        target_nz;
    logic [15:0] yaw;
    logic [15:0] pitch;
  } asp_event_t;

  function automatic logic [7:0] lead_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = CH_DOLLAR;
      3'd1: ch = 8'h4B;
      3'd2: ch = 8'h32;
      3'd3: ch = 8'h33;
      3'd4: ch = CH_ZERO;
      3'd5: ch = CH_COMMA;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [15:0] angle_value(input logic [16:0] whole,
                                              input logic [6:0]  frac,
                                              input logic [1:0]  digits,
                                              input logic        neg);
    logic [23:0] f;
    logic [23:0] mag;
    logic [15:0] res;
    f   = (digits == 2'd1) ? 24'(frac) * 24'd10 : 24'(frac);
    mag = 24'(whole) * 24'd100 + f;
    if (neg) begin
      if (mag >= 24'd32768) res = 16'h8000;
      else                  res = 16'(24'd0 - mag);
    end else begin
      if (mag > 24'd32767) res = 16'h7FFF;
      else                 res = mag[15:0];
    end
    return res;
  endfunction

endpackage

// ===== src/asp_parser.sv =====
// Line parser: per-byte state update of the sentence grammar and line length check.
module asp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  output asp_pkg::asp_event_t event_o
);
  import asp_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    logic [3:0]       phase;
    logic [2:0]       prefix_pos;
    logic             failed;
    logic             terminated;
    logic [16:0]      accum;
    logic [6:0]       frac;
    logic [1:0]       digits;
    logic             neg;
    logic             any_digit;
    logic [7:0]       pend_flag;
    logic [15:0]      pend_yaw;
    logic [15:0]      pend_pitch;
    logic [7:0]       pend_target;
  } asp_state_t;

  asp_state_t state_q, state_d;
  asp_event_t event_d;

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  digit;
  logic [20:0] next_whole;
  logic [15:0] angle_q;
  logic        eot_pitch;
  logic        eot_target;
  logic        is_sign;
  logic [3:0]  eph;
  logic        eph_int;
  logic        eph_frac;

  assign c          = data_byte_i;
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit      = c[3:0];
  assign next_whole = 21'(state_q.accum) * 21'd10 + 21'(digit);
  assign angle_q    = angle_value(state_q.accum, state_q.frac, state_q.digits, state_q.neg);
  assign eot_pitch  = (state_q.phase >= PH_PITCH_SIGN) && (state_q.phase <= PH_PITCH_FRAC) &&
                      state_q.any_digit;
  assign eot_target = (state_q.phase == PH_TARGET) && state_q.any_digit;
  assign is_sign    = (state_q.phase == PH_YAW_SIGN) || (state_q.phase == PH_PITCH_SIGN);
  assign eph        = is_sign ? state_q.phase + 4'd1 : state_q.phase;
  assign eph_int    = (eph == PH_YAW_INT) || (eph == PH_PITCH_INT);
  assign eph_frac   = (eph == PH_YAW_FRAC) || (eph == PH_PITCH_FRAC);

  always_comb begin
    state_d = state_q;
    event_d = '0;
    if (c == CH_DOLLAR) begin
      state_d.line_length = '0;
      state_d.phase       = PH_PREFIX;
      state_d.prefix_pos  = '0;
      state_d.failed      = 1'b0;
      state_d.terminated  = 1'b0;
      state_d.accum       = '0;
      state_d.frac        = '0;
      state_d.digits      = '0;
      state_d.neg         = 1'b0;
      state_d.any_digit   = 1'b0;
    end
    if (c == CH_CR) begin
      state_d = state_q;
    end else if (c == CH_LF) begin
      if (state_q.line_length != '0) begin
        if (!state_q.terminated && !state_q.failed) begin
          if (eot_pitch) begin
            state_d.pend_pitch  = angle_q;
            state_d.pend_target = state_q.pend_flag;
          end else if (eot_target) begin
            state_d.pend_target = state_q.accum[7:0];
          end else begin
            state_d.failed = 1'b1;
          end
        end
        event_d.valid     = 1'b1;
        event_d.accepted  = !state_d.failed;
        event_d.flag_nz   = state_d.pend_flag != 8'd0;
        event_d.target_nz = state_d.pend_target != 8'd0;
        event_d.yaw       = state_d.pend_yaw;
        event_d.pitch     = state_d.pend_pitch;
      end
      state_d.line_length = '0;
      state_d.phase       = PH_PREFIX;
      state_d.prefix_pos  = '0;
      state_d.failed      = 1'b0;
      state_d.terminated  = 1'b0;
      state_d.accum       = '0;
      state_d.frac        = '0;
      state_d.digits      = '0;
      state_d.neg         = 1'b0;
      state_d.any_digit   = 1'b0;
    end else if (state_d.line_length >= LEN_W'(LINE_CAPACITY - 1)) begin
      state_d.line_length = '0;
      state_d.phase       = PH_PREFIX;
      state_d.prefix_pos  = '0;
      state_d.failed      = 1'b0;
      state_d.terminated  = 1'b0;
      state_d.accum       = '0;
      state_d.frac        = '0;
      state_d.digits      = '0;
      state_d.neg         = 1'b0;
      state_d.any_digit   = 1'b0;
      event_d.valid       = 1'b1;
      event_d.accepted    = 1'b0;
      event_d.flag_nz     = state_q.pend_flag != 8'd0;
      event_d.target_nz   = state_q.pend_target != 8'd0;
      event_d.yaw         = state_q.pend_yaw;
      event_d.pitch       = state_q.pend_pitch;
    end else begin
      state_d.line_length = state_d.line_length + LEN_W'(1);
      if (!state_d.terminated && !state_d.failed) begin
        if (c == CH_NUL) begin
          state_d.terminated = 1'b1;
          if (eot_pitch) begin
            state_d.pend_pitch  = angle_q;
            state_d.pend_target = state_q.pend_flag;
          end else if (eot_target) begin
            state_d.pend_target = state_q.accum[7:0];
          end else begin
            state_d.failed = 1'b1;
          end
        end else if (state_d.phase == PH_PREFIX) begin
          if ((state_d.prefix_pos >= PREFIX_LEN) || (c != lead_char(state_d.prefix_pos))) begin
            state_d.failed = 1'b1;
          end else begin
            state_d.prefix_pos = state_d.prefix_pos + 3'd1;
            if (state_d.prefix_pos == PREFIX_LEN) state_d.phase = PH_FLAG;
          end
        end else if ((state_q.phase == PH_FLAG) || (state_q.phase == PH_TARGET)) begin
          if (is_digit) begin
            state_d.any_digit = 1'b1;
            if (next_whole > 21'd255) state_d.failed = 1'b1;
            state_d.accum = 17'(next_whole[7:0]);
          end else if ((state_q.phase == PH_FLAG) && state_q.any_digit && (c == CH_COMMA)) begin
            state_d.pend_flag = state_q.accum[7:0];
            state_d.accum     = '0;
            state_d.frac      = '0;
            state_d.digits    = '0;
            state_d.neg       = 1'b0;
            state_d.any_digit = 1'b0;
            state_d.phase     = PH_YAW_SIGN;
          end else begin
            state_d.failed = 1'b1;
          end
        end else begin
          if (is_sign) state_d.phase = eph;
          if (is_sign && (c == CH_MINUS)) begin
            state_d.neg = 1'b1;
          end else if (is_sign && (c == CH_PLUS)) begin
            state_d.neg = state_q.neg;
          end else if (eph_int && is_digit) begin
            state_d.any_digit = 1'b1;
            state_d.accum = (next_whole > 21'(ACCUM_MAX)) ? ACCUM_MAX : next_whole[16:0];
          end else if (eph_int && (c == CH_DOT)) begin
            state_d.phase = eph + 4'd1;
          end else if (eph_frac && is_digit) begin
            state_d.any_digit = 1'b1;
            if (state_q.digits < 2'd2) begin
              state_d.frac   = 7'(8'(state_q.frac) * 8'd10 + 8'(digit));
              state_d.digits = state_q.digits + 2'd1;
            end
          end else if (!eph_int && !eph_frac) begin
            state_d.failed = 1'b1;
          end else if (!state_q.any_digit || (c != CH_COMMA)) begin
            state_d.failed = 1'b1;
          end else begin
            if (eph <= PH_YAW_FRAC) begin
              state_d.pend_yaw = angle_q;
              state_d.phase    = PH_PITCH_SIGN;
            end else begin
              state_d.pend_pitch = angle_q;
              state_d.phase      = PH_TARGET;
            end
            state_d.accum     = '0;
            state_d.frac      = '0;
            state_d.digits    = '0;
            state_d.neg       = 1'b0;
            state_d.any_digit = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (take_i) begin
      state_q <= state_d;
    end
  end

  assign event_o = take_i ? event_d : '0;

endmodule

// ===== src/asp_frame.sv =====
// Latest frame, frame and error counters, and the result register.
module asp_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asp_pkg::asp_event_t event_i,
  input  logic                out_take_i,
  output logic                out_valid_o,
  output logic                frame_accepted_o,
  output logic                have_frame_o,
  output logic                frame_valid_o,
  output logic                target_found_o,
  output logic [15:0]         yaw_o,
  output logic [15:0]         pitch_o,
  output logic [31:0]         frames_o,
  output logic [31:0]         errors_o
);
  import asp_pkg::*;

  logic        out_valid_q;
  logic        accepted_q;
  logic        present_q;
  logic        valid_q;
  logic        target_q;
  logic [15:0] yaw_q;
  logic [15:0] pitch_q;
  logic [31:0] frames_q;
  logic [31:0] errors_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      present_q   <= 1'b0;
      valid_q     <= 1'b0;
      target_q    <= 1'b0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      frames_q    <= '0;
      errors_q    <= '0;
    end else begin
      if (event_i.valid) begin
        out_valid_q <= 1'b1;
        accepted_q  <= event_i.accepted;
        if (event_i.accepted) begin
          present_q <= 1'b1;
          valid_q   <= event_i.flag_nz;
          target_q  <= event_i.target_nz;
          yaw_q     <= event_i.yaw;
          pitch_q   <= event_i.pitch;
          frames_q  <= frames_q + 32'd1;
        end else begin
          errors_q  <= errors_q + 32'd1;
        end
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_accepted_o = accepted_q;
  assign have_frame_o     = present_q;
  assign frame_valid_o    = valid_q;
  assign target_found_o   = target_q;
  assign yaw_o            = yaw_q;
  assign pitch_o          = pitch_q;
  assign frames_o         = frames_q;
  assign errors_o         = errors_q;

endmodule

// ===== src/angle_sentence_parser.sv =====
// Top level of the angle sentence parser: byte input channel and frame result channel.
//
// The input channel carries one received byte per item on data_byte_i, qualified by
// in_valid_i and held off by in_stall_o. Each byte updates the line parser in the
// cycle it is accepted. A line feed that ends a non-empty line, or a byte that would
// overflow the line buffer, produces one result item; all other bytes produce none.
// The result item appears on out_valid_o in the cycle after the byte that causes it and
// reports the accept flag, the latest frame and both counters.
// Throughput is one byte per cycle while no result waits under out_stall_i: the parser
// state and the result register are each updated once per cycle by a single pass of logic.
// While a result waits under out_stall_i, in_stall_o is raised so no byte is taken;
// once the result is taken, the next byte is accepted in that same cycle.
// Reset clears the line state, the latest frame and both counters, and empties the
// result register; the block accepts bytes in the first cycle after reset.
module angle_sentence_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_accepted_o,
  output logic        have_frame_o,
  output logic        frame_valid_o,
  output logic        target_found_o,
  output logic signed [15:0] yaw_centideg_o,
  output logic signed [15:0] pitch_centideg_o,
  output logic [31:0] frames_seen_o,
  output logic [31:0] errors_seen_o
);
  import asp_pkg::*;

  logic       in_take;
  logic       out_take;
  asp_event_t event_w;
  logic [15:0] yaw_w;
  logic [15:0] pitch_w;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;

  asp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (in_take),
    .data_byte_i (data_byte_i),
    .event_o     (event_w)
  );

  asp_frame u_frame (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .event_i          (event_w),
    .out_take_i       (out_take),
    .out_valid_o      (out_valid_o),
    .frame_accepted_o (frame_accepted_o),
    .have_frame_o     (have_frame_o),
    .frame_valid_o    (frame_valid_o),
    .target_found_o   (target_found_o),
    .yaw_o            (yaw_w),
    .pitch_o          (pitch_w),
    .frames_o         (frames_seen_o),
    .errors_o         (errors_seen_o)
  );

  assign yaw_centideg_o   = signed'(yaw_w);
  assign pitch_centideg_o = signed'(pitch_w);

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled without a pending result.");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(in_valid_i && !in_stall_o)) |=> !out_valid_o)
    else $error("Result stayed valid after it was taken.");

  a_frames_with_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(frames_seen_o) |-> (out_valid_o && frame_accepted_o))
    else $error("Frame counter moved without an accepted frame.");

  a_errors_with_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(errors_seen_o) |-> (out_valid_o && !frame_accepted_o))
    else $error("Error counter moved without a rejected line.");

endmodule
